// ===== hdl/tts_pkg.sv =====
// Shared types and constants for the typed tag stack.
package tts_pkg;

    // Default color reported when no color entry is held (opaque white).
    localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_PUSH_COLOR = 3'd0,
        CMD_PUSH_PRIM  = 3'd1,
        CMD_POP_TOP    = 3'd2,
        CMD_POP_COLOR  = 3'd3,
        CMD_POP_PRIM   = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_EMPTY_COLOR = 2'd0,
        CFG_EMPTY_PRIM  = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SCAN_START,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/typed_tag_stack_unit.sv =====
// Typed tag stack: a bounded stack of color and primitive entries with a sequencer.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  tuser: command; tdata: payload
//  m_*       out        m_tvalid / m_tready  tdata: ok, colors, tag, empty, depth
//  cfg_*     in         cfg_wr_en            cfg_index selects, cfg_wr_data value
//
// Each command is taken in the idle state and then walks the entry memory through
// its single registered read port, with a read state and a check or write state for
// each entry visited. Every command ends with a scan from the top until both a color
// and a primitive are seen or the bottom is reached; a typed pop first searches down
// for its entry and moves every entry above it down by one slot.
// Reset clears the entry count and loads both default registers; memory needs no clearing.
// A finished result is held in an output register, so the next command is accepted
// while the beat waits; the sequencer only stalls when a new result is ready and the
// previous beat has not yet been taken.
module typed_tag_stack_unit #(
    parameter int STACK_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W = ((67 + CNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [2:0]       s_tuser,   // [2:0] command
    input  logic [31:0]      s_tdata,   // [31:0] payload

    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] ok, [32:1] top_color, [64:33] top_primitive, [65] top_is_color,
    // [66] is_empty, then depth, then zero fill
    output logic [OUT_W-1:0] m_tdata,

    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_wr_data
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENT_W  = PAYLOAD_BITS + 1;

    // Entry memory: the top bit is the tag (1 = color), the rest is the payload.
    logic [ENT_W-1:0] mem [STACK_DEPTH];
    logic [ENT_W-1:0] rd_q;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;

    tts_pkg::state_t state_reg, state_next;
    tts_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]     payload_reg, payload_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic            ok_reg, ok_next;
    logic            first_reg, first_next;
    logic            found_c_reg, found_c_next;
    logic            found_p_reg, found_p_next;
    logic            tag_reg, tag_next;
    logic [31:0]     color_reg, color_next;
    logic [31:0]     prim_reg, prim_next;

    logic [31:0]     empty_color_reg;
    logic [31:0]     empty_prim_reg;

    logic            out_valid_reg, out_valid_next;
    logic            out_ok_reg, out_tag_reg, out_empty_reg;
    logic [31:0]     out_color_reg, out_prim_reg;
    logic [CNT_W-1:0] out_depth_reg;
    logic            out_load;

    // Derived views of the registered read data and the latched command.
    logic            rd_tag;
    logic [31:0]     rd_payload32;
    logic [63:0]     payload_ext;
    logic            want_color;
    logic [CNT_W-1:0] idx_plus1;
    logic [CNT_W-1:0] idx_plus2;
    logic [ADDR_W-1:0] top_addr;
    logic            full;

    always_comb begin
        rd_tag       = rd_q[PAYLOAD_BITS];
        rd_payload32 = 32'(64'(rd_q[PAYLOAD_BITS-1:0]));
        payload_ext  = {32'd0, payload_reg};
        want_color   = (cmd_reg == tts_pkg::CMD_POP_COLOR);
        idx_plus1    = CNT_W'(idx_reg) + CNT_W'(1);
        idx_plus2    = CNT_W'(idx_reg) + CNT_W'(2);
        top_addr     = ADDR_W'(count_reg - CNT_W'(1));
        full         = (count_reg == CNT_W'(STACK_DEPTH));
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tts_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tts_pkg::ST_EXEC;
                end
            end
            tts_pkg::ST_EXEC: begin
                if ((cmd_reg == tts_pkg::CMD_POP_COLOR || cmd_reg == tts_pkg::CMD_POP_PRIM)
                    && count_reg != '0) begin
                    state_next = tts_pkg::ST_FIND_RD;
                end else begin
                    state_next = tts_pkg::ST_SCAN_START;
                end
            end
            tts_pkg::ST_FIND_RD: state_next = tts_pkg::ST_FIND_CHK;
            tts_pkg::ST_FIND_CHK: begin
                if (rd_tag == want_color) begin
                    // Removing the top entry needs no move-down.
                    if (idx_plus1 == count_reg) begin
                        state_next = tts_pkg::ST_SCAN_START;
                    end else begin
                        state_next = tts_pkg::ST_SHIFT_RD;
                    end
                end else if (idx_reg == '0) begin
                    state_next = tts_pkg::ST_SCAN_START;
                end else begin
                    state_next = tts_pkg::ST_FIND_RD;
                end
            end
            tts_pkg::ST_SHIFT_RD: state_next = tts_pkg::ST_SHIFT_WR;
            tts_pkg::ST_SHIFT_WR: begin
                if (idx_plus2 == count_reg) begin
                    state_next = tts_pkg::ST_SCAN_START;
                end else begin
                    state_next = tts_pkg::ST_SHIFT_RD;
                end
            end
            tts_pkg::ST_SCAN_START: begin
                if (count_reg == '0) begin
                    state_next = tts_pkg::ST_DONE;
                end else begin
                    state_next = tts_pkg::ST_SCAN_RD;
                end
            end
            tts_pkg::ST_SCAN_RD: state_next = tts_pkg::ST_SCAN_CHK;
            tts_pkg::ST_SCAN_CHK: begin
                if (((found_c_reg || rd_tag) && (found_p_reg || !rd_tag)) || idx_reg == '0) begin
                    state_next = tts_pkg::ST_DONE;
                end else begin
                    state_next = tts_pkg::ST_SCAN_RD;
                end
            end
            tts_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            default: state_next = tts_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output controls of the sequencer.
    always_comb begin
        s_tready     = (state_reg == tts_pkg::ST_IDLE);
        cmd_next     = cmd_reg;
        payload_next = payload_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        ok_next      = ok_reg;
        first_next   = first_reg;
        found_c_next = found_c_reg;
        found_p_next = found_p_reg;
        tag_next     = tag_reg;
        color_next   = color_reg;
        prim_next    = prim_reg;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_q;
        out_load     = 1'b0;

        case (state_reg)
            tts_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = tts_pkg::cmd_t'(s_tuser);
                    payload_next = s_tdata;
                end
            end
            tts_pkg::ST_EXEC: begin
                ok_next  = 1'b0;
                idx_next = top_addr;
                case (cmd_reg)
                    tts_pkg::CMD_PUSH_COLOR, tts_pkg::CMD_PUSH_PRIM: begin
                        if (!full) begin
                            wr_en      = 1'b1;
                            wr_addr    = ADDR_W'(count_reg);
                            wr_data    = {cmd_reg == tts_pkg::CMD_PUSH_COLOR,
                                          payload_ext[PAYLOAD_BITS-1:0]};
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    tts_pkg::CMD_POP_TOP: begin
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    tts_pkg::CMD_QUERY: ok_next = 1'b1;
                    default: ok_next = 1'b0;
                endcase
            end
            tts_pkg::ST_FIND_CHK: begin
                if (rd_tag == want_color) begin
                    ok_next = 1'b1;
                    if (idx_plus1 == count_reg) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end else if (idx_reg != '0) begin
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end
            tts_pkg::ST_SHIFT_RD: begin
                rd_addr = ADDR_W'(idx_plus1);
            end
            tts_pkg::ST_SHIFT_WR: begin
                // Move the entry above the gap down by one slot.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_q;
                if (idx_plus2 == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    idx_next = ADDR_W'(idx_plus1);
                end
            end
            tts_pkg::ST_SCAN_START: begin
                idx_next     = top_addr;
                first_next   = 1'b1;
                found_c_next = 1'b0;
                found_p_next = 1'b0;
                tag_next     = 1'b0;
                color_next   = empty_color_reg;
                prim_next    = empty_prim_reg;
            end
            tts_pkg::ST_SCAN_CHK: begin
                first_next = 1'b0;
                if (first_reg) begin
                    tag_next = rd_tag;
                end
                if (rd_tag && !found_c_reg) begin
                    color_next   = rd_payload32;
                    found_c_next = 1'b1;
                end
                if (!rd_tag && !found_p_reg) begin
                    prim_next    = rd_payload32;
                    found_p_next = 1'b1;
                end
                if (idx_reg != '0) begin
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end
            tts_pkg::ST_DONE: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tts_pkg::ST_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            empty_color_reg <= tts_pkg::WHITE_RGBA;
            empty_prim_reg  <= 32'd0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                if (cfg_index == 1'(tts_pkg::CFG_EMPTY_COLOR)) begin
                    empty_color_reg <= cfg_wr_data;
                end else begin
                    empty_prim_reg <= cfg_wr_data;
                end
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        payload_reg <= payload_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        first_reg   <= first_next;
        found_c_reg <= found_c_next;
        found_p_reg <= found_p_next;
        tag_reg     <= tag_next;
        color_reg   <= color_next;
        prim_reg    <= prim_next;
        if (out_load) begin
            out_ok_reg    <= ok_reg;
            out_color_reg <= color_reg;
            out_prim_reg  <= prim_reg;
            out_tag_reg   <= tag_reg;
            out_empty_reg <= (count_reg == '0);
            out_depth_reg <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_depth_reg, out_empty_reg, out_tag_reg,
                              out_prim_reg, out_color_reg, out_ok_reg});

    // The stack never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count exceeds stack depth");

    // One command moves the count by at most one entry.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("entry count changed by more than one");

    // A move-down always reads a slot below the current count.
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tts_pkg::ST_SHIFT_RD |-> idx_plus1 < count_reg)
        else $error("move-down reads beyond the top entry");

    // A delivered beat reports emptiness consistent with its depth.
    a_empty_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_empty_reg == (out_depth_reg == '0)))
        else $error("empty flag disagrees with depth");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the typed tag stack: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 16;

    // Command codes that the block must reject without touching its state.
    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    // Cycles the receiver refuses beats once, so the block backs up into its input.
    localparam int BACKPRESSURE_CYCLES = 400;
    localparam int BACKPRESSURE_AT     = 60;

    // Idle wait after the last random phase, sized to cover the slowest command.
    localparam int DRAIN_CYCLES = 6 * SLOTS + 24;

    // Packed to match m_tdata: ok lands in bit 0, depth in the top bits.
    typedef struct packed {
        logic [4:0]  depth;
        logic        is_empty;
        logic        top_is_color;
        logic [31:0] top_prim;
        logic [31:0] top_color;
        logic        ok;
    } stack_result_t;

    // One row of the directed table. Rows with typed set carry a hand-written
    // result; all other rows are checked against the predictor.
    typedef struct packed {
        logic [2:0]    cmd;
        logic [31:0]   payload;
        logic [4:0]    reps;
        bit            typed;
        stack_result_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;   // [2:0] command
    logic [31:0] s_tdata;   // [31:0] payload
    logic        m_tvalid;
    logic        m_tready;
    // [0] ok, [32:1] top_color, [64:33] top_primitive, [65] top_is_color,
    // [66] is_empty, [71:67] depth
    logic [71:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wr_data;

    typed_tag_stack_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // Predictor state: a private copy of the stack and of both default registers.
    logic [31:0] slot_payload [SLOTS];
    bit          slot_is_color [SLOTS];
    int          slot_count;
    logic [31:0] idle_color;
    logic [31:0] idle_prim;

    stack_result_t pending_results [$];
    stim_row_t     rows [$];
    int            errors;
    int            beats_taken;

    // Burst shaping: each side draws runs that either have gaps or have none.
    int src_left, snk_left;
    bit src_gappy, snk_gappy;

    function automatic stack_result_t result_of(logic ok, logic [31:0] color,
                                                logic [31:0] prim, logic tag,
                                                logic empty, logic [4:0] depth);
        stack_result_t r;
        r.ok           = ok;
        r.top_color    = color;
        r.top_prim     = prim;
        r.top_is_color = tag;
        r.is_empty     = empty;
        r.depth        = depth;
        return r;
    endfunction

    // Index of the highest entry with the wanted tag, or -1.
    function automatic int topmost_of(bit want_color);
        for (int i = slot_count - 1; i >= 0; i--) begin
            if (slot_is_color[i] == want_color) return i;
        end
        return -1;
    endfunction

    // Applies one command to the predictor's stack and returns what the block reports.
    function automatic stack_result_t stack_after(logic [2:0] cmd, logic [31:0] payload);
        stack_result_t r;
        bit ok;
        int at;
        int ci;
        int pi;
        ok = 1'b0;
        case (cmd)
            tts_pkg::CMD_PUSH_COLOR, tts_pkg::CMD_PUSH_PRIM: begin
                if (slot_count < SLOTS) begin
                    slot_payload[slot_count]  = payload;
                    slot_is_color[slot_count] = (cmd == tts_pkg::CMD_PUSH_COLOR);
                    slot_count++;
                    ok = 1'b1;
                end
            end
            tts_pkg::CMD_POP_TOP: begin
                if (slot_count > 0) begin
                    slot_count--;
                    ok = 1'b1;
                end
            end
            tts_pkg::CMD_POP_COLOR, tts_pkg::CMD_POP_PRIM: begin
                at = topmost_of(cmd == tts_pkg::CMD_POP_COLOR);
                if (at >= 0) begin
                    // Entries above the removed one slide down to close the gap.
                    for (int i = at; i + 1 < slot_count; i++) begin
                        slot_payload[i]  = slot_payload[i + 1];
                        slot_is_color[i] = slot_is_color[i + 1];
                    end
                    slot_count--;
                    ok = 1'b1;
                end
            end
            tts_pkg::CMD_QUERY: ok = 1'b1;
            default:            ok = 1'b0;
        endcase
        ci = topmost_of(1'b1);
        pi = topmost_of(1'b0);
        r.ok           = ok;
        r.top_color    = (ci >= 0) ? slot_payload[ci] : idle_color;
        r.top_prim     = (pi >= 0) ? slot_payload[pi] : idle_prim;
        r.top_is_color = (slot_count > 0) && slot_is_color[slot_count - 1];
        r.is_empty     = (slot_count == 0);
        r.depth        = 5'(slot_count);
        return r;
    endfunction

    task automatic draw_gap(inout int left, inout bit gappy, output int gap);
        if (left == 0) begin
            gappy = ($urandom_range(0, 2) != 0);
            left  = $urandom_range(10, 60);
        end
        left--;
        gap = gappy ? $urandom_range(0, 15) : 0;
    endtask

    // Offers one command and returns at the edge where it was accepted. The caller
    // is always at a rising edge, so valid is assigned at most once per step.
    task automatic send_command(logic [2:0] cmd, logic [31:0] payload,
                                bit typed, stack_result_t want);
        int gap;
        stack_result_t predicted;
        draw_gap(src_left, src_gappy, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        predicted = stack_after(cmd, payload);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both default registers on back-to-back edges while the block is idle.
    task automatic load_defaults(logic [31:0] color, logic [31:0] prim);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= 1'(tts_pkg::CFG_EMPTY_COLOR);
        cfg_wr_data <= color;
        idle_color   = color;
        @(posedge aclk);
        cfg_index   <= 1'(tts_pkg::CFG_EMPTY_PRIM);
        cfg_wr_data <= prim;
        idle_prim    = prim;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random commands with a push bias that drifts, so the stack swings between
    // empty and full and typed removals dig into deep stacks.
    task automatic random_phase(int items);
        int push_pct;
        int roll;
        logic [2:0] cmd;
        logic [31:0] payload;
        push_pct = 50;
        for (int n = 0; n < items; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
            end else if (roll < 8) begin
                cmd = tts_pkg::CMD_QUERY;
            end else if ($urandom_range(0, 99) < push_pct) begin
                cmd = $urandom_range(0, 1) ? tts_pkg::CMD_PUSH_PRIM : tts_pkg::CMD_PUSH_COLOR;
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmd = tts_pkg::CMD_POP_TOP;
                    1:       cmd = tts_pkg::CMD_POP_COLOR;
                    default: cmd = tts_pkg::CMD_POP_PRIM;
                endcase
            end
            case ($urandom_range(0, 9))
                0:       payload = 32'h0000_0000;
                1:       payload = 32'hFFFF_FFFF;
                default: payload = $urandom;
            endcase
            send_command(cmd, payload, 1'b0, '0);
        end
        drain();
    endtask

    task automatic check_result(stack_result_t got);
        stack_result_t want;
        if (pending_results.size() == 0) begin
            if (errors < 10) $display("ERROR: result beat %h with nothing expected", got);
            errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.top_color !== want.top_color ||
                got.top_prim !== want.top_prim || got.top_is_color !== want.top_is_color ||
                got.is_empty !== want.is_empty || got.depth !== want.depth) begin
                if (errors < 10) begin
                    $display("ERROR: beat %0d expected ok=%b color=%h prim=%h tag=%b empty=%b depth=%0d",
                             beats_taken, want.ok, want.top_color, want.top_prim,
                             want.top_is_color, want.is_empty, want.depth);
                    $display("       got              ok=%b color=%h prim=%h tag=%b empty=%b depth=%0d",
                             got.ok, got.top_color, got.top_prim,
                             got.top_is_color, got.is_empty, got.depth);
                end
                errors++;
            end
        end
    endtask

    // Receiver: random stalls per beat, plus one long hold-off early in the random part.
    initial begin
        int gap;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            draw_gap(snk_left, snk_gappy, gap);
            if (!held && beats_taken >= BACKPRESSURE_AT) begin
                gap += BACKPRESSURE_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result(stack_result_t'(m_tdata));
            beats_taken++;
        end
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        stim_row_t row;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= '0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= 1'b0;
        cfg_wr_data <= '0;
        errors      = 0;
        beats_taken = 0;
        src_left    = 0;
        snk_left    = 0;
        slot_count  = 0;
        idle_color  = tts_pkg::WHITE_RGBA;
        idle_prim   = 32'h0;

        // Empty stack: every pop fails, undefined commands fail, the tag reads 0.
        rows.push_back('{tts_pkg::CMD_QUERY,     32'h0, 5'd1, 1'b1,
                         result_of(1'b1, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        rows.push_back('{tts_pkg::CMD_POP_TOP,   32'h0, 5'd1, 1'b1,
                         result_of(1'b0, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        rows.push_back('{tts_pkg::CMD_POP_COLOR, 32'h0, 5'd1, 1'b1,
                         result_of(1'b0, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        rows.push_back('{tts_pkg::CMD_POP_PRIM,  32'h0, 5'd1, 1'b1,
                         result_of(1'b0, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        rows.push_back('{CMD_UNDEF_LO,  32'h0, 5'd1, 1'b1,
                         result_of(1'b0, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        rows.push_back('{CMD_UNDEF_HI,  32'hFFFF_FFFF, 5'd1, 1'b1,
                         result_of(1'b0, tts_pkg::WHITE_RGBA, 32'h0, 1'b0, 1'b1, 5'd0)});
        // All-ones payloads of both kinds.
        rows.push_back('{tts_pkg::CMD_PUSH_COLOR, 32'hFFFF_FFFF, 5'd1, 1'b1,
                         result_of(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 5'd1)});
        rows.push_back('{tts_pkg::CMD_PUSH_PRIM,  32'hFFFF_FFFF, 5'd1, 1'b1,
                         result_of(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd2)});
        // Removing the primitive under a color closes a gap in the middle.
        rows.push_back('{tts_pkg::CMD_PUSH_COLOR, 32'h0, 5'd1, 1'b0, '0});
        rows.push_back('{tts_pkg::CMD_POP_PRIM,   32'h0, 5'd1, 1'b0, '0});
        // Fill to the top, then a refused push and a color pop that moves fourteen entries down.
        rows.push_back('{tts_pkg::CMD_PUSH_PRIM,  32'h0, 5'd14, 1'b0, '0});
        rows.push_back('{tts_pkg::CMD_PUSH_COLOR, 32'h8000_0001, 5'd1, 1'b0, '0});
        rows.push_back('{tts_pkg::CMD_POP_COLOR,  32'h0, 5'd1, 1'b0, '0});
        rows.push_back('{tts_pkg::CMD_QUERY,      32'h0, 5'd1, 1'b0, '0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[r]) begin
            row = rows[r];
            for (int k = 0; k < row.reps; k++)
                send_command(row.cmd, row.payload + 32'(k), row.typed, row.want);
        end
        drain();

        // Random phases under different default registers: extremes, random values, opposite extremes.
        load_defaults(32'h0000_0000, 32'hFFFF_FFFF);
        random_phase(170);
        load_defaults($urandom, $urandom);
        random_phase(170);
        load_defaults(32'hFFFF_FFFF, 32'h0000_0000);
        random_phase(170);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
